// ===== rtl/core/nea_pkg.sv =====
// Shared types, constants and memory port structs for the adjacency builder.
`timescale 1ns / 1ps

package nea_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int NODE_W      = 10;
  localparam int MAX_EDGES   = 4096;
  localparam int EDGE_W      = 12;
  localparam int ECNT_W      = 13;
  localparam int MAX_DEGREE  = 12;
  localparam int DEG_W       = 4;
  localparam int QUAD_DEGREE = 4;
  localparam int ADJ_DEPTH   = MAX_NODES * MAX_DEGREE;
  localparam int ADJ_AW      = 14;
  localparam int EP_W        = 2 * NODE_W;
  localparam int NCFG_W      = 11;
  localparam int SWEEP_W     = NODE_W + 1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [EDGE_W-1:0]  edge_t;
  typedef logic [ECNT_W-1:0]  ecnt_t;
  typedef logic [DEG_W-1:0]   deg_t;
  typedef logic [ADJ_AW-1:0]  adj_addr_t;
  typedef logic [EP_W-1:0]    ep_t;
  typedef logic [NCFG_W-1:0]  ncfg_t;
  typedef logic [SWEEP_W-1:0] sweep_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_MISSING    = 2'd1,
    ST_LIST_FULL  = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic      ep_we;
    edge_t     ep_waddr;
    ep_t       ep_wdata;
    edge_t     ep_raddr;
    logic      adj_we;
    adj_addr_t adj_waddr;
    edge_t     adj_wdata;
    adj_addr_t adj_raddr;
    logic      deg_we;
    node_t     deg_waddr;
    deg_t      deg_wdata;
    node_t     deg_raddr;
  } mem_req_t;

  typedef struct packed {
    ep_t   ep_rdata;
    edge_t adj_rdata;
    deg_t  deg_rdata;
  } mem_rsp_t;

  typedef struct packed {
    edge_t   edge_index;
    logic    added_at_first;
    logic    added_at_second;
    status_t status;
    logic    mostly_quadrilateral;
    logic    build_done;
  } result_t;

endpackage

// ===== rtl/core/nea_in_if.sv =====
// Input channel carrying one edge as a node pair with its flags.
`timescale 1ns / 1ps

interface nea_in_if;
  logic                 valid;
  logic                 ready;
  nea_pkg::node_t       first_node;
  nea_pkg::node_t       second_node;
  logic                 endpoint_missing;
  logic                 last_edge;

  modport source (output valid, output first_node, output second_node,
                  output endpoint_missing, output last_edge, input ready);
  modport sink (input valid, input first_node, input second_node,
                input endpoint_missing, input last_edge, output ready);
endinterface

// ===== rtl/core/nea_out_if.sv =====
// Result channel carrying the outcome for one edge.
`timescale 1ns / 1ps

interface nea_out_if;
  logic              valid;
  logic              ready;
  nea_pkg::edge_t    edge_index;
  logic              added_at_first;
  logic              added_at_second;
  logic [1:0]        status;
  logic              mostly_quadrilateral;
  logic              build_done;

  modport source (output valid, output edge_index, output added_at_first,
                  output added_at_second, output status,
                  output mostly_quadrilateral, output build_done, input ready);
  modport sink (input valid, input edge_index, input added_at_first,
                input added_at_second, input status,
                input mostly_quadrilateral, input build_done, output ready);
endinterface

// ===== rtl/core/nea_cfg_if.sv =====
// Configuration write channel carrying the node count register.
`timescale 1ns / 1ps

interface nea_cfg_if;
  logic           valid;
  logic           ready;
  nea_pkg::ncfg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/nea_mem.sv =====
// Endpoint table, adjacency list store and degree store, with registered read data.
`timescale 1ns / 1ps

module nea_mem (
  input  logic              clk,
  input  nea_pkg::mem_req_t req,
  output nea_pkg::mem_rsp_t rsp
);

  nea_pkg::ep_t   ep_mem  [nea_pkg::MAX_EDGES];
  nea_pkg::edge_t adj_mem [nea_pkg::ADJ_DEPTH];
  nea_pkg::deg_t  deg_mem [nea_pkg::MAX_NODES];

  always_ff @(posedge clk) begin
    if (req.ep_we) begin
      ep_mem[req.ep_waddr] <= req.ep_wdata;
    end
    if (req.adj_we) begin
      adj_mem[req.adj_waddr] <= req.adj_wdata;
    end
    if (req.deg_we) begin
      deg_mem[req.deg_waddr] <= req.deg_wdata;
    end
    rsp.ep_rdata  <= ep_mem[req.ep_raddr];
    rsp.adj_rdata <= adj_mem[req.adj_raddr];
    rsp.deg_rdata <= deg_mem[req.deg_raddr];
  end

endmodule

// ===== rtl/core/nea_ctrl.sv =====
// Sequencer that walks the adjacency lists, appends edges and sweeps the degrees.
`timescale 1ns / 1ps

module nea_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  nea_in_if.sink             in_ch,
  input  nea_pkg::ncfg_t     num_nodes,
  output nea_pkg::mem_req_t  req,
  input  nea_pkg::mem_rsp_t  rsp,
  output logic               res_valid,
  input  logic               res_ready,
  output nea_pkg::result_t   res
);

  typedef enum logic [10:0] {
    S_INIT   = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_DEGA   = 11'b00000000100,
    S_DEGB   = 11'b00000001000,
    S_DEGCHK = 11'b00000010000,
    S_WADJ   = 11'b00000100000,
    S_WEP    = 11'b00001000000,
    S_WCMP   = 11'b00010000000,
    S_APPEND = 11'b00100000000,
    S_SWEEP  = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  function automatic nea_pkg::adj_addr_t adj_addr(input nea_pkg::node_t node,
                                                  input nea_pkg::deg_t slot);
    adj_addr = nea_pkg::adj_addr_t'(node) * nea_pkg::adj_addr_t'(nea_pkg::MAX_DEGREE)
             + nea_pkg::adj_addr_t'(slot);
  endfunction

  state_t            state_r, state_nxt;
  nea_pkg::node_t    a_r, a_nxt, b_r, b_nxt;
  logic              last_r, last_nxt;
  nea_pkg::edge_t    e_r, e_nxt;
  nea_pkg::ecnt_t    ecnt_r, ecnt_nxt;
  nea_pkg::deg_t     deg_a_r, deg_a_nxt, deg_b_r, deg_b_nxt;
  logic              side_r, side_nxt;
  nea_pkg::deg_t     slot_r, slot_nxt;
  logic              add_a_r, add_a_nxt, add_b_r, add_b_nxt;
  nea_pkg::status_t  status_r, status_nxt;
  logic              quad_r, quad_nxt;
  nea_pkg::ncfg_t    cnt_r, cnt_nxt;
  nea_pkg::sweep_t   sweep_r, sweep_nxt;
  logic              sweep_vld_r, sweep_vld_nxt;
  nea_pkg::node_t    sweep_prev_r, sweep_prev_nxt;

  logic              in_fire;
  nea_pkg::node_t    node;
  nea_pkg::node_t    other;
  nea_pkg::deg_t     deg;
  logic              hit;
  logic              quad_inc;
  nea_pkg::ncfg_t    cnt_sum;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign node  = side_r ? b_r : a_r;
  assign other = side_r ? a_r : b_r;
  assign deg   = side_r ? deg_b_r : deg_a_r;
  assign hit   = (rsp.ep_rdata[nea_pkg::NODE_W-1:0] == other) ||
                 (rsp.ep_rdata[nea_pkg::EP_W-1:nea_pkg::NODE_W] == other);

  assign quad_inc = sweep_vld_r &&
                    (rsp.deg_rdata == nea_pkg::deg_t'(nea_pkg::QUAD_DEGREE)) &&
                    ({1'b0, sweep_prev_r} < num_nodes);
  assign cnt_sum  = cnt_r + nea_pkg::ncfg_t'(quad_inc);

  assign res_valid = (state_r == S_DONE);
  assign res.edge_index           = e_r;
  assign res.added_at_first       = add_a_r;
  assign res.added_at_second      = add_b_r;
  assign res.status               = status_r;
  assign res.mostly_quadrilateral = quad_r;
  assign res.build_done           = last_r;

  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    last_nxt       = last_r;
    e_nxt          = e_r;
    ecnt_nxt       = ecnt_r;
    deg_a_nxt      = deg_a_r;
    deg_b_nxt      = deg_b_r;
    side_nxt       = side_r;
    slot_nxt       = slot_r;
    add_a_nxt      = add_a_r;
    add_b_nxt      = add_b_r;
    status_nxt     = status_r;
    quad_nxt       = quad_r;
    cnt_nxt        = cnt_r;
    sweep_nxt      = sweep_r;
    sweep_vld_nxt  = 1'b0;
    sweep_prev_nxt = sweep_r[nea_pkg::NODE_W-1:0];

    req           = '0;
    req.ep_waddr  = ecnt_r[nea_pkg::EDGE_W-1:0];
    req.ep_wdata  = {in_ch.second_node, in_ch.first_node};
    req.ep_raddr  = rsp.adj_rdata;
    req.adj_waddr = adj_addr(node, deg);
    req.adj_wdata = e_r;
    req.adj_raddr = adj_addr(node, slot_r);
    req.deg_waddr = node;
    req.deg_wdata = deg + nea_pkg::deg_t'(1);
    req.deg_raddr = a_r;

    unique case (state_r)
      S_INIT: begin
        req.deg_we    = !sweep_r[nea_pkg::SWEEP_W-1];
        req.deg_waddr = sweep_r[nea_pkg::NODE_W-1:0];
        req.deg_wdata = '0;
        sweep_nxt     = sweep_r + nea_pkg::sweep_t'(1);
        if (sweep_r[nea_pkg::SWEEP_W-1]) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          a_nxt     = in_ch.first_node;
          b_nxt     = in_ch.second_node;
          last_nxt  = in_ch.last_edge;
          add_a_nxt = 1'b0;
          add_b_nxt = 1'b0;
          quad_nxt  = 1'b0;
          if (ecnt_r[nea_pkg::ECNT_W-1]) begin
            status_nxt = nea_pkg::ST_TABLE_FULL;
            e_nxt      = '1;
            state_nxt  = in_ch.last_edge ? S_SWEEP : S_DONE;
          end else begin
            req.ep_we = 1'b1;
            e_nxt     = ecnt_r[nea_pkg::EDGE_W-1:0];
            ecnt_nxt  = ecnt_r + nea_pkg::ecnt_t'(1);
            if (in_ch.endpoint_missing) begin
              status_nxt = nea_pkg::ST_MISSING;
              state_nxt  = in_ch.last_edge ? S_SWEEP : S_DONE;
            end else begin
              status_nxt = nea_pkg::ST_OK;
              state_nxt  = S_DEGA;
            end
          end
          sweep_nxt = '0;
          cnt_nxt   = '0;
        end
      end
      S_DEGA: begin
        req.deg_raddr = a_r;
        state_nxt     = S_DEGB;
      end
      S_DEGB: begin
        deg_a_nxt     = rsp.deg_rdata;
        req.deg_raddr = b_r;
        state_nxt     = S_DEGCHK;
      end
      S_DEGCHK: begin
        deg_b_nxt = rsp.deg_rdata;
        side_nxt  = 1'b0;
        slot_nxt  = '0;
        if ((deg_a_r >= nea_pkg::deg_t'(nea_pkg::MAX_DEGREE)) ||
            (rsp.deg_rdata >= nea_pkg::deg_t'(nea_pkg::MAX_DEGREE))) begin
          status_nxt = nea_pkg::ST_LIST_FULL;
          state_nxt  = last_r ? S_SWEEP : S_DONE;
        end else begin
          state_nxt = S_WADJ;
        end
      end
      S_WADJ: begin
        state_nxt = (slot_r >= deg) ? S_APPEND : S_WEP;
      end
      S_WEP: begin
        state_nxt = S_WCMP;
      end
      S_WCMP: begin
        if (hit) begin
          if (!side_r) begin
            side_nxt  = 1'b1;
            slot_nxt  = '0;
            state_nxt = S_WADJ;
          end else begin
            state_nxt = last_r ? S_SWEEP : S_DONE;
          end
        end else begin
          slot_nxt  = slot_r + nea_pkg::deg_t'(1);
          state_nxt = S_WADJ;
        end
      end
      S_APPEND: begin
        if (deg < nea_pkg::deg_t'(nea_pkg::MAX_DEGREE)) begin
          req.adj_we = 1'b1;
          req.deg_we = 1'b1;
          if (!side_r || (a_r == b_r)) begin
            deg_a_nxt = deg_a_r + nea_pkg::deg_t'(1);
          end
          if (side_r || (a_r == b_r)) begin
            deg_b_nxt = deg_b_r + nea_pkg::deg_t'(1);
          end
        end
        if (!side_r) begin
          add_a_nxt = 1'b1;
          side_nxt  = 1'b1;
          slot_nxt  = '0;
          state_nxt = S_WADJ;
        end else begin
          add_b_nxt = 1'b1;
          state_nxt = last_r ? S_SWEEP : S_DONE;
        end
      end
      S_SWEEP: begin
        req.deg_raddr = sweep_r[nea_pkg::NODE_W-1:0];
        req.deg_waddr = sweep_r[nea_pkg::NODE_W-1:0];
        req.deg_wdata = '0;
        cnt_nxt       = cnt_sum;
        if (!sweep_r[nea_pkg::SWEEP_W-1]) begin
          req.deg_we    = 1'b1;
          sweep_vld_nxt = 1'b1;
          sweep_nxt     = sweep_r + nea_pkg::sweep_t'(1);
        end else begin
          quad_nxt  = cnt_sum > (num_nodes >> 1);
          ecnt_nxt  = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ecnt_r      <= '0;
      sweep_r     <= '0;
      sweep_vld_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      ecnt_r      <= ecnt_nxt;
      sweep_r     <= sweep_nxt;
      sweep_vld_r <= sweep_vld_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    last_r       <= last_nxt;
    e_r          <= e_nxt;
    deg_a_r      <= deg_a_nxt;
    deg_b_r      <= deg_b_nxt;
    side_r       <= side_nxt;
    slot_r       <= slot_nxt;
    add_a_r      <= add_a_nxt;
    add_b_r      <= add_b_nxt;
    status_r     <= status_nxt;
    quad_r       <= quad_nxt;
    sweep_prev_r <= sweep_prev_nxt;
  end

endmodule

// ===== rtl/core/node_edge_adjacency_builder_unit.sv =====
// Top level of the node/edge adjacency builder with result and config registers.
//
//   Channel  Direction  Payload
//   in_ch    sink       first_node, second_node, endpoint_missing, last_edge
//   out_ch   source     edge_index, added flags, status, mostly_quadrilateral, build_done
//   cfg_ch   sink       data (num_nodes)
//
// One edge is in work at a time. The work on an edge depends on d1 and d2, the degrees
// of its endpoints, set by the walk through the adjacency and endpoint memories with
// one read each per step. The last edge of a build adds a sweep over the degree memory
// that counts and clears it. After reset a clearing pass over the degree memory runs
// before the first transfer is taken.
// A finished result waits in the output register while the next edge is taken.
`timescale 1ns / 1ps

module node_edge_adjacency_builder_unit (
  input  logic     clk,
  input  logic     rst_n,
  nea_in_if.sink   in_ch,
  nea_out_if.source out_ch,
  nea_cfg_if.sink  cfg_ch
);

  nea_pkg::mem_req_t req;
  nea_pkg::mem_rsp_t rsp;
  nea_pkg::result_t  res;
  logic              res_valid;
  logic              res_ready;
  nea_pkg::ncfg_t    num_nodes_r;
  logic              out_valid_r;
  nea_pkg::result_t  out_res_r;

  nea_mem u_mem (
    .clk (clk),
    .req (req),
    .rsp (rsp)
  );

  nea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .num_nodes (num_nodes_r),
    .req       (req),
    .rsp       (rsp),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign cfg_ch.ready = 1'b1;
  assign res_ready    = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_nodes_r <= nea_pkg::ncfg_t'(nea_pkg::MAX_NODES);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        num_nodes_r <= cfg_ch.data;
      end
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid                = out_valid_r;
  assign out_ch.edge_index           = out_res_r.edge_index;
  assign out_ch.added_at_first       = out_res_r.added_at_first;
  assign out_ch.added_at_second      = out_res_r.added_at_second;
  assign out_ch.status               = out_res_r.status;
  assign out_ch.mostly_quadrilateral = out_res_r.mostly_quadrilateral;
  assign out_ch.build_done           = out_res_r.build_done;

endmodule
